// ===== src/mcdmx_pkg.sv =====
// ============================================================================
// mcdmx_pkg
// Types, constants and gain tables shared by the stereo downmix block.
// ============================================================================
package mcdmx_pkg;

    // Field and datapath widths
    localparam int RAW_W      = 64;
    localparam int Q_W        = 32;   // signed Q1.30 sample, range [-1,1]
    localparam int MAG_W      = 31;   // magnitude of a Q1.30 sample
    localparam int GAIN_W     = 17;   // unsigned Q1.16 gain
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int SUM_W      = 40;
    localparam int PCM_W      = 16;
    localparam int MASK_W     = 18;
    localparam int CHAN_W     = 5;
    localparam int CONT_W     = 7;
    localparam int VBITS_W    = 6;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SAMPLE_IS_FLOAT = 3'd0;
    localparam logic [2:0] REG_CONTAINER_BITS  = 3'd1;
    localparam logic [2:0] REG_VALID_BITS      = 3'd2;
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd3;
    localparam logic [2:0] REG_MAP_ENABLE      = 3'd4;
    localparam logic [2:0] REG_CHANNEL_MASK    = 3'd5;

    // Unity in Q1.30
    localparam logic [MAG_W-1:0]        Q30_ONE = 31'h4000_0000;
    localparam logic signed [SUM_W-1:0] SUM_ONE = 40'sh00_4000_0000;

    // Gain codes
    typedef enum logic [2:0] {
        GAIN_ZERO,
        GAIN_QUARTER,
        GAIN_HALF,
        GAIN_M3,
        GAIN_ONE
    } gain_t;

    // Speaker positions of the channel mask
    typedef enum logic [4:0] {
        SPK_FL, SPK_FR, SPK_FC, SPK_LFE, SPK_BL, SPK_BR, SPK_FLC, SPK_FRC, SPK_BC,
        SPK_SL, SPK_SR, SPK_TC, SPK_TFL, SPK_TFC, SPK_TFR, SPK_TBL, SPK_TBC, SPK_TBR,
        SPK_NONE
    } speaker_t;

    // Input request payload
    typedef struct packed {
        logic [RAW_W-1:0] sample_raw;
        logic             end_of_packet;
    } sample_t;

    // Output request payload
    typedef struct packed {
        logic signed [PCM_W-1:0] left_pcm;
        logic signed [PCM_W-1:0] right_pcm;
        logic                    packet_end;
        logic                    format_error;
    } pair_t;

    // Sample format settings seen by the converter
    typedef struct packed {
        logic               sample_is_float;
        logic [CONT_W-1:0]  container_bits;
        logic [VBITS_W-1:0] valid_bits;
    } conv_cfg_t;

    // Per-sample frame control carried down the pipeline
    typedef struct packed {
        logic  first;
        logic  last;
        gain_t gain_l;
        gain_t gain_r;
        logic  eop;
    } frame_ctrl_t;

    // Q1.16 value of a gain code
    function automatic logic [GAIN_W-1:0] gain_value(gain_t g);
        logic [GAIN_W-1:0] v;
        case (g)
            GAIN_ZERO:    v = 17'd0;
            GAIN_QUARTER: v = 17'd16384;
            GAIN_HALF:    v = 17'd32768;
            GAIN_M3:      v = 17'd46341;
            GAIN_ONE:     v = 17'd65536;
            default:      v = 17'd0;
        endcase
        return v;
    endfunction

    // Left gain of a speaker position
    function automatic gain_t map_gain_left(speaker_t s);
        gain_t g;
        case (s)
            SPK_FL, SPK_BL, SPK_SL, SPK_TFL, SPK_TBL, SPK_FLC: g = GAIN_ONE;
            SPK_FR, SPK_BR, SPK_SR, SPK_TFR, SPK_TBR:          g = GAIN_ZERO;
            SPK_FC, SPK_TFC:                                   g = GAIN_M3;
            SPK_LFE, SPK_BC:                                   g = GAIN_HALF;
            default:                                           g = GAIN_QUARTER;
        endcase
        return g;
    endfunction

    // Right gain of a speaker position
    function automatic gain_t map_gain_right(speaker_t s);
        gain_t g;
        case (s)
            SPK_FR, SPK_BR, SPK_SR, SPK_TFR, SPK_TBR, SPK_FRC: g = GAIN_ONE;
            SPK_FL, SPK_BL, SPK_SL, SPK_TFL, SPK_TBL:          g = GAIN_ZERO;
            SPK_FC, SPK_TFC:                                   g = GAIN_M3;
            SPK_LFE, SPK_BC:                                   g = GAIN_HALF;
            default:                                           g = GAIN_QUARTER;
        endcase
        return g;
    endfunction

endpackage

// ===== src/mcdmx_conv.sv =====
// ============================================================================
// mcdmx_conv
// Converts one raw integer or IEEE float sample into signed Q1.30.
// ============================================================================
module mcdmx_conv import mcdmx_pkg::*; (
    input  logic [RAW_W-1:0]    sample_raw,
    input  conv_cfg_t           cfg,
    output logic signed [Q_W-1:0] q,
    output logic                format_error
);

    logic [31:0]        byte_mask;
    logic [CONT_W-1:0]  vsel;
    logic [VBITS_W-1:0] vbits;
    logic [4:0]         lshift;
    logic [31:0]        int_word;
    logic signed [Q_W-1:0] int_q;

    logic               is_dbl;
    logic               neg;
    logic               exp_max;
    logic               frac_nz;
    logic [52:0]        mant;
    logic signed [12:0] unb;
    logic signed [12:0] rsh;
    logic [5:0]         sh;
    logic [52:0]        shifted;
    logic [MAG_W-1:0]   mag;
    logic [Q_W-1:0]     mag_ext;
    logic signed [Q_W-1:0] flt_q;

    // Integer path: byte window, valid width, align sign to bit 31
    always_comb
    begin
        case (cfg.container_bits[6:3])
            4'd0, 4'd1: byte_mask = 32'h0000_00FF;
            4'd2:       byte_mask = 32'h0000_FFFF;
            4'd3:       byte_mask = 32'h00FF_FFFF;
            default:    byte_mask = 32'hFFFF_FFFF;
        endcase
        vsel = (cfg.valid_bits == '0) ? cfg.container_bits : CONT_W'(cfg.valid_bits);
        if (vsel == '0)
            vbits = VBITS_W'(1);
        else if (vsel > CONT_W'(32))
            vbits = VBITS_W'(32);
        else
            vbits = vsel[VBITS_W-1:0];
        lshift   = 5'(VBITS_W'(32) - vbits);
        int_word = (sample_raw[31:0] & byte_mask) << lshift;
        // arithmetic shift gives both the Q1.30 scaling and floor for 32 bits
        int_q    = $signed(int_word) >>> 1;
    end

    // Float path: unpack into a double-style mantissa and unbiased exponent
    always_comb
    begin
        is_dbl = (cfg.container_bits == CONT_W'(64));
        if (is_dbl)
        begin
            neg     = sample_raw[63];
            exp_max = &sample_raw[62:52];
            frac_nz = |sample_raw[51:0];
            if (sample_raw[62:52] == '0)
            begin
                mant = {1'b0, sample_raw[51:0]};
                unb  = -13'sd1022;
            end
            else
            begin
                mant = {1'b1, sample_raw[51:0]};
                unb  = $signed({2'b00, sample_raw[62:52]}) - 13'sd1023;
            end
        end
        else
        begin
            neg     = sample_raw[31];
            exp_max = &sample_raw[30:23];
            frac_nz = |sample_raw[22:0];
            if (sample_raw[30:23] == '0)
            begin
                mant = {1'b0, sample_raw[22:0], 29'd0};
                unb  = -13'sd126;
            end
            else
            begin
                mant = {1'b1, sample_raw[22:0], 29'd0};
                unb  = $signed({5'b00000, sample_raw[30:23]}) - 13'sd127;
            end
        end

        // right shift of at least 23, rounded half away from zero
        rsh     = 13'sd22 - unb;
        sh      = 6'(rsh) - 6'd1;
        shifted = mant >> sh;
        if (exp_max)
            mag = frac_nz ? '0 : Q30_ONE;
        else if (!unb[12])
            mag = Q30_ONE;
        else if (rsh > 13'sd63)
            mag = '0;
        else
            mag = MAG_W'(shifted[30:1]) + MAG_W'(shifted[0]);

        mag_ext = {1'b0, mag};
        flt_q   = neg ? -$signed(mag_ext) : $signed(mag_ext);
    end

    // Format select
    always_comb
    begin
        format_error = 1'b0;
        if (!cfg.sample_is_float)
            q = int_q;
        else if (cfg.container_bits == CONT_W'(32) || cfg.container_bits == CONT_W'(64))
            q = flt_q;
        else
        begin
            q            = '0;
            format_error = 1'b1;
        end
    end

endmodule

// ===== src/mcdmx_gain.sv =====
// ============================================================================
// mcdmx_gain
// Weights a Q1.30 sample by a Q1.16 gain, rounded half away from zero.
// ============================================================================
module mcdmx_gain import mcdmx_pkg::*; (
    input  logic signed [Q_W-1:0] q,
    input  gain_t                 gain,
    output logic signed [Q_W-1:0] term
);

    logic              neg;
    logic [Q_W-1:0]    abs_q;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    rounded;

    // Sign-magnitude multiply, round the dropped 16 bits
    always_comb
    begin
        neg     = q[Q_W-1];
        abs_q   = neg ? Q_W'(-q) : Q_W'(q);
        mag     = abs_q[MAG_W-1:0];
        prod    = PROD_W'(mag) * PROD_W'(gain_value(gain));
        rounded = Q_W'(prod[PROD_W-1:16]) + Q_W'(prod[15]);
        term    = neg ? -$signed(rounded) : $signed(rounded);
    end

endmodule

// ===== src/mcdmx_pcm.sv =====
// ============================================================================
// mcdmx_pcm
// Clamps a frame sum to [-1,1] and rounds it to 16-bit PCM.
// ============================================================================
module mcdmx_pcm import mcdmx_pkg::*; (
    input  logic signed [SUM_W-1:0] sum,
    output logic signed [PCM_W-1:0] pcm
);

    logic signed [SUM_W-1:0] clamped;
    logic                    neg;
    logic [SUM_W-1:0]        abs_s;
    logic [MAG_W-1:0]        mag;
    logic [PCM_W:0]          rounded;
    logic signed [PCM_W+1:0] signed_r;

    always_comb
    begin
        // clamp to unity
        if (sum > SUM_ONE)
            clamped = SUM_ONE;
        else if (sum < -SUM_ONE)
            clamped = -SUM_ONE;
        else
            clamped = sum;

        // scale by 32768, half away from zero
        neg      = clamped[SUM_W-1];
        abs_s    = neg ? SUM_W'(-clamped) : SUM_W'(clamped);
        mag      = abs_s[MAG_W-1:0];
        rounded  = (PCM_W+1)'(mag[MAG_W-1:15]) + (PCM_W+1)'(mag[14]);
        signed_r = neg ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});

        // only +1.0 exceeds the positive range
        if (signed_r > 18'sd32767)
            pcm = 16'sh7FFF;
        else
            pcm = signed_r[PCM_W-1:0];
    end

endmodule

// ===== src/multichannel_to_stereo_pcm16_downmix.sv =====
// ============================================================================
// multichannel_to_stereo_pcm16_downmix
// Speaker-mask driven stereo downmix of interleaved samples to 16-bit PCM.
// ============================================================================
// Usage:
//  - sample channel (sample_valid/sample_ready/sample): one channel sample per
//    request, interleaved channel_count samples per frame.
//  - pair channel (pair_valid/pair_ready/pair): one stereo PCM16 request per
//    frame, after the frame's last channel.
//  - APB port: format, channel count, map enable and speaker mask at byte
//    addresses 0,4,...,20; write only while the datapath holds no work.
// Throughput is one sample per cycle while sample_ready is high. A frame's
// last sample passes the input register, convert, weight and accumulate
// stages and the PCM output register before the frame's pair is valid.
// Reset clears the config registers to their defaults, the channel counter,
// the frame sums and all pipeline valids. When the receiver stalls, the
// output register holds its pair and one more finished pair can wait in the
// stage behind it. Samples that do not end a frame keep being summed; once a
// frame's last sample is held at the sum stage and the weight and input
// stages behind it are full, sample_ready drops.
// ============================================================================
module multichannel_to_stereo_pcm16_downmix import mcdmx_pkg::*; #(
    parameter int MAX_CHANNELS = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,
    output logic                  pair_valid,
    input  logic                  pair_ready,
    output pair_t                 pair
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = CHAN_W + 1;
    localparam logic [CHAN_W-1:0] MAX_COUNT = CHAN_W'(MAX_CHANNELS);

    // Config registers
    logic               sample_is_float_reg;
    logic [CONT_W-1:0]  container_bits_reg;
    logic [VBITS_W-1:0] valid_bits_reg;
    logic [CHAN_W-1:0]  channel_count_reg;
    logic               map_enable_reg;
    logic [MASK_W-1:0]  channel_mask_reg;
    logic [2:0]         reg_idx;
    logic               cfg_write;
    conv_cfg_t          conv_cfg;

    // Frame tracking
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W:0]     cnt_inc;
    logic [MASK_W-1:0]  rem_reg;
    logic [MASK_W-1:0]  rem_next;
    logic [MASK_W-1:0]  rem_cur;
    logic [MASK_W-1:0]  rem_clr;
    logic [CHAN_W-1:0]  count_clamped;
    speaker_t           spk;
    frame_ctrl_t        ctrl_in;
    logic               accept;

    // Pipeline stages
    logic               s1_valid_reg;
    logic [RAW_W-1:0]   s1_raw_reg;
    frame_ctrl_t        s1_ctrl_reg;
    logic               s2_valid_reg;
    logic signed [Q_W-1:0] s2_q_reg;
    frame_ctrl_t        s2_ctrl_reg;
    logic               s2_ferr_reg;
    logic               s3_valid_reg;
    logic signed [Q_W-1:0] s3_term_l_reg;
    logic signed [Q_W-1:0] s3_term_r_reg;
    frame_ctrl_t        s3_ctrl_reg;
    logic               s3_ferr_reg;
    logic signed [SUM_W-1:0] sum_l_reg;
    logic signed [SUM_W-1:0] sum_r_reg;
    logic signed [SUM_W-1:0] sum_l_next;
    logic signed [SUM_W-1:0] sum_r_next;
    logic               s4_valid_reg;
    logic signed [SUM_W-1:0] s4_sum_l_reg;
    logic signed [SUM_W-1:0] s4_sum_r_reg;
    logic               s4_eop_reg;
    logic               s4_ferr_reg;
    logic               out_valid_reg;
    pair_t              pair_reg;

    logic signed [Q_W-1:0]   conv_q;
    logic                    conv_ferr;
    logic signed [Q_W-1:0]   term_l;
    logic signed [Q_W-1:0]   term_r;
    logic signed [PCM_W-1:0] pcm_l;
    logic signed [PCM_W-1:0] pcm_r;

    logic free_out, free1, free2, free3, free4;
    logic take1, take2, take3, take4;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_is_float_reg <= 1'b0;
            container_bits_reg  <= CONT_W'(16);
            valid_bits_reg      <= VBITS_W'(16);
            channel_count_reg   <= CHAN_W'(2);
            map_enable_reg      <= 1'b1;
            channel_mask_reg    <= MASK_W'(3);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_SAMPLE_IS_FLOAT: sample_is_float_reg <= pwdata[0];
                REG_CONTAINER_BITS:  container_bits_reg  <= pwdata[CONT_W-1:0];
                REG_VALID_BITS:      valid_bits_reg      <= pwdata[VBITS_W-1:0];
                REG_CHANNEL_COUNT:   channel_count_reg   <= pwdata[CHAN_W-1:0];
                REG_MAP_ENABLE:      map_enable_reg      <= pwdata[0];
                REG_CHANNEL_MASK:    channel_mask_reg    <= pwdata[MASK_W-1:0];
                default:             ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            REG_SAMPLE_IS_FLOAT: prdata = APB_DATA_W'(sample_is_float_reg);
            REG_CONTAINER_BITS:  prdata = APB_DATA_W'(container_bits_reg);
            REG_VALID_BITS:      prdata = APB_DATA_W'(valid_bits_reg);
            REG_CHANNEL_COUNT:   prdata = APB_DATA_W'(channel_count_reg);
            REG_MAP_ENABLE:      prdata = APB_DATA_W'(map_enable_reg);
            REG_CHANNEL_MASK:    prdata = APB_DATA_W'(channel_mask_reg);
            default:             prdata = '0;
        endcase
    end

    assign conv_cfg = '{sample_is_float: sample_is_float_reg,
                        container_bits:  container_bits_reg,
                        valid_bits:      valid_bits_reg};

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    assign free_out     = !out_valid_reg || pair_ready;
    assign take4        = s4_valid_reg && free_out;
    assign free4        = !s4_valid_reg || free_out;
    assign take3        = s3_valid_reg && (free4 || !s3_ctrl_reg.last);
    assign free3        = !s3_valid_reg || take3;
    assign take2        = s2_valid_reg && free3;
    assign free2        = !s2_valid_reg || free3;
    assign take1        = s1_valid_reg && free2;
    assign free1        = !s1_valid_reg || free2;
    assign sample_ready = free1;
    assign accept       = sample_valid && sample_ready;

    // ------------------------------------------------------------------
    // Channel position and gain select at acceptance
    // ------------------------------------------------------------------
    always_comb
    begin
        if (channel_count_reg == '0)
            count_clamped = CHAN_W'(1);
        else if (channel_count_reg > MAX_COUNT)
            count_clamped = MAX_COUNT;
        else
            count_clamped = channel_count_reg;

        ctrl_in.first = (cnt_reg == '0);
        rem_cur       = ctrl_in.first ? channel_mask_reg : rem_reg;

        // lowest speaker bit still in the mask
        spk = SPK_NONE;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (rem_cur[i])
                spk = speaker_t'(5'(i));
        end
        rem_clr  = rem_cur & (rem_cur - MASK_W'(1));
        rem_next = map_enable_reg ? rem_clr : rem_cur;

        if (map_enable_reg)
        begin
            ctrl_in.gain_l = map_gain_left(spk);
            ctrl_in.gain_r = map_gain_right(spk);
        end
        else if (count_clamped == CHAN_W'(1))
        begin
            ctrl_in.gain_l = GAIN_ONE;
            ctrl_in.gain_r = GAIN_ONE;
        end
        else if (cnt_reg == CNT_W'(0))
        begin
            ctrl_in.gain_l = GAIN_ONE;
            ctrl_in.gain_r = GAIN_ZERO;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            ctrl_in.gain_l = GAIN_ZERO;
            ctrl_in.gain_r = GAIN_ONE;
        end
        else
        begin
            ctrl_in.gain_l = GAIN_QUARTER;
            ctrl_in.gain_r = GAIN_QUARTER;
        end

        // frame ends when the count is reached, also after a count change
        cnt_inc      = {1'b0, cnt_reg} + (CNT_W+1)'(1);
        ctrl_in.last = (CMP_W'(cnt_inc) >= CMP_W'(count_clamped));
        cnt_next     = ctrl_in.last ? '0 : cnt_inc[CNT_W-1:0];
        ctrl_in.eop  = sample.end_of_packet;
    end

    // ------------------------------------------------------------------
    // Datapath units
    // ------------------------------------------------------------------
    mcdmx_conv u_conv (
        .sample_raw   (s1_raw_reg),
        .cfg          (conv_cfg),
        .q            (conv_q),
        .format_error (conv_ferr)
    );

    mcdmx_gain u_gain_l (
        .q    (s2_q_reg),
        .gain (s2_ctrl_reg.gain_l),
        .term (term_l)
    );

    mcdmx_gain u_gain_r (
        .q    (s2_q_reg),
        .gain (s2_ctrl_reg.gain_r),
        .term (term_r)
    );

    // Frame sums restart on the first channel
    assign sum_l_next = (s3_ctrl_reg.first ? '0 : sum_l_reg) + SUM_W'(s3_term_l_reg);
    assign sum_r_next = (s3_ctrl_reg.first ? '0 : sum_r_reg) + SUM_W'(s3_term_r_reg);

    mcdmx_pcm u_pcm_l (
        .sum (s4_sum_l_reg),
        .pcm (pcm_l)
    );

    mcdmx_pcm u_pcm_r (
        .sum (s4_sum_r_reg),
        .pcm (pcm_r)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rem_reg       <= '0;
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
                rem_reg <= rem_next;
            end
            if (take3)
            begin
                sum_l_reg <= sum_l_next;
                sum_r_reg <= sum_r_next;
            end
            if (free1)
                s1_valid_reg <= accept;
            if (free2)
                s2_valid_reg <= s1_valid_reg;
            if (free3)
                s3_valid_reg <= s2_valid_reg;
            if (free4)
                s4_valid_reg <= s3_valid_reg && s3_ctrl_reg.last;
            if (free_out)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_raw_reg  <= sample.sample_raw;
            s1_ctrl_reg <= ctrl_in;
        end
        if (take1)
        begin
            s2_q_reg    <= conv_q;
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_ferr_reg <= conv_ferr;
        end
        if (take2)
        begin
            s3_term_l_reg <= term_l;
            s3_term_r_reg <= term_r;
            s3_ctrl_reg   <= s2_ctrl_reg;
            s3_ferr_reg   <= s2_ferr_reg;
        end
        if (take3 && s3_ctrl_reg.last)
        begin
            s4_sum_l_reg <= sum_l_next;
            s4_sum_r_reg <= sum_r_next;
            s4_eop_reg   <= s3_ctrl_reg.eop;
            s4_ferr_reg  <= s3_ferr_reg;
        end
        if (take4)
        begin
            pair_reg.left_pcm     <= pcm_l;
            pair_reg.right_pcm    <= pcm_r;
            pair_reg.packet_end   <= s4_eop_reg;
            pair_reg.format_error <= s4_ferr_reg;
        end
    end

    assign pair_valid = out_valid_reg;
    assign pair       = pair_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // channel counter never passes the largest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < MAX_CHANNELS)
        else $error("channel counter out of range");

    // a finished frame waiting on a full stage ahead of it is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_ctrl_reg.last && !free4) |=> s3_valid_reg)
        else $error("frame result dropped while stalled");

    // a taken pair with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && pair_ready && !s4_valid_reg) |=> !pair_valid)
        else $error("pair repeated after it was taken");

endmodule
